// ===== hdl/edmt_pkg.sv =====
// ----------------------------------------------------------------------------
// edmt_pkg
// shared types for the egg drop minimum trials core: controller states and
// the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package edmt_pkg;

  localparam int EGG_W   = 5;
  localparam int FLOOR_W = 16;
  localparam int DROPS_W = 14;
  localparam int DROPS_LIMIT = 16383;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } edmt_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } edmt_cmd_t;

  typedef struct packed {
    logic reached;
  } edmt_stat_t;

endpackage

// ===== hdl/edmt_datapath.sv =====
// ----------------------------------------------------------------------------
// edmt_datapath
// query registers, per-egg coverage lanes, trial counter and result register
// ----------------------------------------------------------------------------
module edmt_datapath #(
  parameter int MAX_EGGS   = 16,
  parameter int MAX_FLOORS = 16383
) (
  input  logic                           clk,
  input  logic [edmt_pkg::EGG_W-1:0]     egg_count,
  input  logic [edmt_pkg::FLOOR_W-1:0]   floor_count,
  input  edmt_pkg::edmt_cmd_t            cmd,
  output edmt_pkg::edmt_stat_t           stat,
  output logic [edmt_pkg::DROPS_W-1:0]   min_drops
);
  import edmt_pkg::*;

  localparam int CW  = $clog2(MAX_FLOORS + 1);
  localparam int IW  = (MAX_EGGS > 1) ? $clog2(MAX_EGGS) : 1;
  localparam int EXW = (IW + 1 > EGG_W) ? IW + 1 : EGG_W;
  localparam int TXW = (CW > DROPS_W) ? CW : DROPS_W;

  logic [IW-1:0]  eidx;
  logic [CW-1:0]  floors;
  logic [CW-1:0]  trial;
  logic [CW-1:0]  cov [MAX_EGGS];
  logic [CW-1:0]  cov_next [MAX_EGGS];
  logic [DROPS_W-1:0] result;

  logic [EXW-1:0] egg_ext;
  logic [IW-1:0]  eidx_next;
  logic [CW-1:0]  floors_next;
  logic [TXW-1:0] trial_ext;

  // clamp eggs to 1..MAX_EGGS, stored as eggs - 1
  always_comb begin
    egg_ext = EXW'(egg_count);
    if (egg_ext == '0) begin
      eidx_next = '0;
    end else if (egg_ext > EXW'(MAX_EGGS)) begin
      eidx_next = IW'(MAX_EGGS - 1);
    end else begin
      eidx_next = IW'(egg_ext - EXW'(1));
    end
  end

  always_comb begin
    if (floor_count > FLOOR_W'(MAX_FLOORS)) begin
      floors_next = CW'(MAX_FLOORS);
    end else begin
      floors_next = CW'(floor_count);
    end
  end

  // one lane per egg count, all updated from the previous trial's values
  for (genvar e = 0; e < MAX_EGGS; e++) begin : g_lane
    logic [CW-1:0] prev;
    logic [CW:0]   sum;
    if (e == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = cov[e-1];
    end
    assign sum = {1'b0, prev} + {1'b0, cov[e]} + (CW+1)'(1);
    assign cov_next[e] = (sum > (CW+1)'(MAX_FLOORS)) ? CW'(MAX_FLOORS) : sum[CW-1:0];

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        cov[e] <= '0;
      end else if (cmd.step) begin
        cov[e] <= cov_next[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      eidx   <= eidx_next;
      floors <= floors_next;
      trial  <= '0;
    end else if (cmd.step) begin
      trial  <= trial + CW'(1);
    end
  end

  assign trial_ext = TXW'(trial);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (trial_ext > TXW'(DROPS_LIMIT)) begin
        result <= DROPS_W'(DROPS_LIMIT);
      end else begin
        result <= trial_ext[DROPS_W-1:0];
      end
    end
  end

  assign stat.reached = (cov[eidx] >= floors);
  assign min_drops    = result;

endmodule

// ===== hdl/edmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// edmt_ctrl
// query sequencer: takes a beat, steps trials until coverage reaches the
// floor count, then hands the answer to the output register
// ----------------------------------------------------------------------------
module edmt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  edmt_pkg::edmt_stat_t  stat,
  output edmt_pkg::edmt_cmd_t   cmd
);
  import edmt_pkg::*;

  edmt_state_t state, state_next;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.reached) begin
          if (out_free) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== hdl/egg_drop_min_trials_core.sv =====
// ----------------------------------------------------------------------------
// egg_drop_min_trials_core
// fewest worst-case drops for a given egg and floor count
// ----------------------------------------------------------------------------
// One query is taken per input beat and answered with one output beat. The
// core counts trials upward; each clock cycle applies one trial to every
// per-egg coverage lane at once. A query takes its beat in the idle state,
// then steps the trial loop until the lane for its egg count reaches the
// floor count; the last pass of the loop loads the output register, and
// the core returns to idle. The loop runs longest for one egg and a
// floor count at or above MAX_FLOORS. If the output register still holds
// an answer that has not been taken downstream when the loop ends, the
// core waits for it. Floor counts above MAX_FLOORS are clamped, an egg
// count of 0 is treated as 1 and counts above MAX_EGGS as MAX_EGGS. A
// new beat is taken as soon as the previous answer has moved to the
// output register, even if that answer has not yet been taken downstream.
module egg_drop_min_trials_core #(
  parameter int MAX_EGGS   = 16,
  parameter int MAX_FLOORS = 16383
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // egg_count[4:0], floor_count[20:5], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // min_drops[13:0], zero pad
);
  import edmt_pkg::*;

  edmt_cmd_t           cmd;
  edmt_stat_t          stat;
  logic [DROPS_W-1:0]  min_drops;

  edmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  edmt_datapath #(
    .MAX_EGGS   (MAX_EGGS),
    .MAX_FLOORS (MAX_FLOORS)
  ) u_datapath (
    .clk         (clk),
    .egg_count   (s_tdata[EGG_W-1:0]),
    .floor_count (s_tdata[EGG_W+FLOOR_W-1:EGG_W]),
    .cmd         (cmd),
    .stat        (stat),
    .min_drops   (min_drops)
  );

  assign m_tdata = {{(16-DROPS_W){1'b0}}, min_drops};

endmodule

// ===== hdl/edmt_checker.sv =====
// ----------------------------------------------------------------------------
// edmt_checker
// port-level checks on the egg drop minimum trials core
// ----------------------------------------------------------------------------
module edmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // one query at a time: no beat right after a taken beat
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accepting a query");

  // no result out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:14] == 2'b00)
    else $error("output pad bits set");

endmodule

bind egg_drop_min_trials_core edmt_checker u_edmt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
